// ----- rtl/sfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the segmented frame reassembler
// frame kinds, status codes, stream widths and the job word that the front
// end hands to the back end through the queue
// ----------------------------------------------------------------------------
package sfr_pkg;

   // stream widths
   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 48;

   // frame geometry
   localparam logic [3:0]  FRAME_BYTES   = 4'd8;
   localparam int unsigned PAYLOAD_SLOTS = 7;
   localparam int unsigned QUEUE_DEPTH   = 2;

   // request kind on tuser
   localparam logic MODE_FEED  = 1'b0;
   localparam logic MODE_CLEAR = 1'b1;

   // result kind on tuser
   localparam logic ITEM_BYTE   = 1'b0;
   localparam logic ITEM_STATUS = 1'b1;

   // protocol control nibble
   localparam logic [3:0] KIND_SINGLE = 4'h0;
   localparam logic [3:0] KIND_FIRST  = 4'h1;
   localparam logic [3:0] KIND_CONSEC = 4'h2;

   // status codes
   localparam logic [1:0] STATUS_REJECTED = 2'd0;
   localparam logic [1:0] STATUS_PENDING  = 2'd1;
   localparam logic [1:0] STATUS_COMPLETE = 2'd2;

   // one classified frame: payload bytes to emit, then the status word
   typedef struct packed {
      logic [2:0]                        count;
      logic [11:0]                       start;
      logic [PAYLOAD_SLOTS-1:0][7:0]     data;
      logic [1:0]                        status;
      logic                              flow_control;
      logic [11:0]                       message_length;
      logic [11:0]                       received_length;
   } job_type;

endpackage
`default_nettype wire

// ----- rtl/segmented_frame_reassembler_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segmented_frame_reassembler_top: receive-side iso-tp frame reassembler
// classifies can frames, tracks the message context and streams accepted
// payload bytes with their message offsets, followed by one status word
// ----------------------------------------------------------------------------
// A fed frame produces n payload words (n = accepted bytes, 0 to 7) and then
// one status word with tlast set. The output sequencer emits one word per
// cycle while rsp_tready is high and sets the sustained rate. The front end
// takes a request word every cycle as long as the two-entry job queue has
// room, so a new frame is taken while the previous one is still streaming
// out. A clear command gives no result. Bytes are not buffered; the context
// holds only lengths, the next sequence number and the complete and
// flow-control flags.
// ----------------------------------------------------------------------------
module segmented_frame_reassembler_top #(
   parameter int unsigned MAX_MESSAGE = 4095
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request stream
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // byte_count[3:0], byte_0[11:4], byte_1 .. byte_7 in 8-bit steps up to [67:60]
   input  wire logic [sfr_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode: feed frame or clear context
   input  wire logic                           req_tuser,
   // result stream
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // byte_offset[11:0], byte_value[19:12], frame_status[21:20],
   // send_flow_control[22], message_length[34:23], received_length[46:35]
   output logic [sfr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // item_kind: payload byte or status summary
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import sfr_pkg::*;

   logic    push;
   job_type push_job;
   logic    push_ready;
   logic    head_valid;
   job_type head_job;
   logic    pop;

   // frame classifier and context
   sfr_front #(
      .MAX_MESSAGE (MAX_MESSAGE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .job_valid  (push),
      .job        (push_job),
      .job_ready  (push_ready)
   );

   // job queue
   sfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   // result sequencer
   sfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ----- rtl/sfr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_front: frame classifier and reassembly context
// takes one request word a cycle while the queue has room, checks frame kind,
// length and sequence, updates the context and pushes one job per fed frame into the queue
// ----------------------------------------------------------------------------
module sfr_front #(
   parameter int unsigned MAX_MESSAGE = 4095
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [sfr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                          req_tuser,
   output logic                               job_valid,
   output sfr_pkg::job_type                   job,
   input  wire logic                          job_ready
);
   import sfr_pkg::*;

   localparam logic [12:0] MAX_LEN = 13'(MAX_MESSAGE);

   // reassembly context
   logic [11:0] stored_ff, stored_in;
   logic [11:0] expected_ff, expected_in;
   logic [3:0]  seq_ff, seq_in;
   logic        complete_ff, complete_in;
   logic        fc_ff, fc_in;

   logic        accept;
   logic [3:0]  flen;
   logic [3:0]  kind;
   logic [3:0]  nib;
   logic [7:0]  fb [0:8];
   logic [11:0] ff_len;
   logic [3:0]  avail;
   logic [3:0]  take;
   logic [11:0] remain;
   logic [12:0] sum;
   logic        base2;
   logic [2:0]  count;
   logic [11:0] start;
   logic [1:0]  status;

   assign req_tready = job_ready;
   assign accept     = req_tvalid && req_tready;
   assign job_valid  = accept && (req_tuser == MODE_FEED);

   // unpack the frame bytes, slot 8 pads the shifted view
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         fb[i] = req_tdata[4 + 8*i +: 8];
      end
      fb[8] = 8'h00;
   end

   assign flen   = (req_tdata[3:0] > FRAME_BYTES) ? FRAME_BYTES : req_tdata[3:0];
   assign kind   = fb[0][7:4];
   assign nib    = fb[0][3:0];
   assign ff_len = {nib, fb[1]};

   // classify the frame and work out the next context
   always_comb begin
      stored_in   = stored_ff;
      expected_in = expected_ff;
      seq_in      = seq_ff;
      complete_in = complete_ff;
      fc_in       = fc_ff;
      count       = 3'd0;
      start       = 12'd0;
      base2       = 1'b0;
      status      = STATUS_REJECTED;
      avail       = 4'd0;
      take        = 4'd0;
      remain      = 12'd0;
      sum         = 13'd0;
      if (flen >= 4'd2) begin
         fc_in = 1'b0;
         unique case (kind)
            KIND_SINGLE: begin
               if (nib != 4'd0 && nib <= flen - 4'd1 && {9'd0, nib} <= MAX_LEN) begin
                  count       = nib[2:0];
                  stored_in   = {8'd0, nib};
                  expected_in = {8'd0, nib};
                  complete_in = 1'b1;
                  status      = STATUS_COMPLETE;
               end
            end
            KIND_FIRST: begin
               base2 = 1'b1;
               avail = flen - 4'd2;
               if (ff_len != 12'd0 && {1'b0, ff_len} <= MAX_LEN) begin
                  take        = ({8'd0, avail} > ff_len) ? ff_len[3:0] : avail;
                  count       = take[2:0];
                  stored_in   = {8'd0, take};
                  expected_in = ff_len;
                  complete_in = ({8'd0, take} >= ff_len);
                  seq_in      = 4'd1;
                  fc_in       = !complete_in;
                  status      = complete_in ? STATUS_COMPLETE : STATUS_PENDING;
               end
            end
            KIND_CONSEC: begin
               avail  = flen - 4'd1;
               remain = (expected_ff >= stored_ff) ? expected_ff - stored_ff : 12'd0;
               take   = ({8'd0, avail} > remain) ? remain[3:0] : avail;
               sum    = {1'b0, stored_ff} + {9'd0, take};
               if (expected_ff != 12'd0 && !complete_ff && nib == seq_ff) begin
                  seq_in = seq_ff + 4'd1;
                  if (sum <= MAX_LEN) begin
                     count       = take[2:0];
                     start       = stored_ff;
                     stored_in   = sum[11:0];
                     complete_in = (sum[11:0] >= expected_ff);
                     status      = complete_in ? STATUS_COMPLETE : STATUS_PENDING;
                  end
               end
            end
            default: begin
               status = STATUS_REJECTED;
            end
         endcase
      end
   end

   // job word for the back end
   always_comb begin
      job.count           = count;
      job.start           = start;
      job.status          = status;
      job.flow_control    = fc_in;
      job.message_length  = expected_in;
      job.received_length = stored_in;
      for (int i = 0; i < PAYLOAD_SLOTS; i++) begin
         job.data[i] = base2 ? fb[i + 2] : fb[i + 1];
      end
   end

   // context registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff   <= 12'd0;
         expected_ff <= 12'd0;
         seq_ff      <= 4'd0;
         complete_ff <= 1'b0;
         fc_ff       <= 1'b0;
      end else if (accept) begin
         if (req_tuser == MODE_CLEAR) begin
            stored_ff   <= 12'd0;
            expected_ff <= 12'd0;
            seq_ff      <= 4'd0;
            complete_ff <= 1'b0;
            fc_ff       <= 1'b0;
         end else begin
            stored_ff   <= stored_in;
            expected_ff <= expected_in;
            seq_ff      <= seq_in;
            complete_ff <= complete_in;
            fc_ff       <= fc_in;
         end
      end
   end

   // context invariants
   a_stored_le_expected: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= expected_ff)
      else $error("stored length beyond announced length");
   a_complete_has_length: assert property (@(posedge clock) disable iff (reset)
      complete_ff |-> expected_ff != 12'd0)
      else $error("complete flag without a message");
   a_fc_only_open: assert property (@(posedge clock) disable iff (reset)
      fc_ff |-> !complete_ff)
      else $error("flow control wanted on a complete message");

endmodule
`default_nettype wire

// ----- rtl/sfr_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_queue: job queue between front and back end
// small register fifo, head word shown combinationally
// ----------------------------------------------------------------------------
module sfr_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  sfr_pkg::job_type      push_job,
   output logic                  push_ready,
   output logic                  head_valid,
   output sfr_pkg::job_type      head_job,
   input  wire logic             pop
);
   import sfr_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (cnt_ff != FULL_CNT);
   assign head_valid = (cnt_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("queue fill count out of range");
   a_cnt_up: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count missed a push");
   a_no_lost_push: assert property (@(posedge clock) disable iff (reset)
      push |-> push_ready)
      else $error("job pushed into a full queue");

endmodule
`default_nettype wire

// ----- rtl/sfr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_back: result sequencer
// walks the head job one word a cycle unless stalled: its payload bytes with
// their message offsets, then the status word, into a registered output stage
// ----------------------------------------------------------------------------
module sfr_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           head_valid,
   input  sfr_pkg::job_type                    head_job,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [sfr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import sfr_pkg::*;

   logic [2:0]            idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   logic [RSP_DATA_W-1:0] data_ff, data_in;
   logic                  user_ff, user_in;
   logic                  last_ff, last_in;
   logic                  load;
   logic                  emit;
   logic                  is_byte;
   logic [11:0]           offset;
   logic [7:0]            value;

   assign load    = !valid_ff || rsp_tready;
   assign emit    = load && head_valid;
   assign is_byte = (idx_ff < head_job.count);
   assign pop     = emit && !is_byte;
   assign offset  = head_job.start + {9'd0, idx_ff};
   assign value   = is_byte ? head_job.data[idx_ff] : 8'h00;

   // next word and walk position
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      user_in  = user_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = head_valid;
      end
      if (emit) begin
         if (is_byte) begin
            idx_in  = idx_ff + 3'd1;
            data_in = {1'b0, 12'd0, 12'd0, 1'b0, STATUS_REJECTED, value, offset};
            user_in = ITEM_BYTE;
            last_in = 1'b0;
         end else begin
            idx_in  = 3'd0;
            data_in = {1'b0, head_job.received_length, head_job.message_length,
                       head_job.flow_control, head_job.status, 8'h00, 12'd0};
            user_in = ITEM_STATUS;
            last_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> idx_ff <= head_job.count)
      else $error("walk position beyond job byte count");
   a_idx_needs_job: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 3'd0 |-> head_valid)
      else $error("job left the queue in mid walk");
   a_pop_rewinds: assert property (@(posedge clock) disable iff (reset)
      pop |=> idx_ff == 3'd0)
      else $error("walk position not rewound after status word");

endmodule
`default_nettype wire
